[hw/rtl/wdps_pkg.sv]
// Shared constants and types for the wet-day precipitation spreader.
`default_nettype none

package wdps_pkg;

   // longest month that the spreading rule handles; longer lengths clamp to it
   localparam int unsigned MAX_PERIOD = 31;

   // mode register codes
   localparam logic [1:0] MODE_PASS = 2'd0;
   localparam logic [1:0] MODE_WET  = 2'd1;
   localparam logic [1:0] MODE_FRAC = 2'd2;

   // status from the wet-day checker
   typedef struct packed {
      logic busy;
      logic wet;
   } wdps_wet_status_type;

endpackage

`default_nettype wire

[hw/rtl/wdps_wet_check.sv]
// Wet-day checker: steps through the event positions one per cycle.
`default_nettype none

module wdps_wet_check (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [4:0]                 len,
   input  wire logic [4:0]                 cnt,
   input  wire logic [4:0]                 day,
   output wdps_pkg::wdps_wet_status_type   status
);

   logic [4:0]  ecnt_ff, ecnt_in;
   logic        hit_ff, hit_in;
   logic        inv_ff, inv_in;
   logic        even_ff, even_in;
   logic [11:0] x2_ff, x2_in;
   logic [11:0] step_ff, step_in;
   logic [11:0] lo_ff, lo_in;
   logic [11:0] hi_ff, hi_in;

   // setup on start, then one position test per cycle
   always_comb begin
      logic [4:0]  half;
      logic        inv;
      logic [4:0]  n;
      logic [5:0]  n2;
      logic [5:0]  dm1;
      logic [5:0]  dp1;
      logic        match;
      half  = len >> 1;
      inv   = cnt > half;
      n     = inv ? (len - cnt) : cnt;
      n2    = {n, 1'b0};
      dm1   = {day, 1'b0} - 6'd1;
      dp1   = {day, 1'b1};
      match = ((x2_ff > lo_ff) && (x2_ff < hi_ff)) ||
              (((x2_ff == lo_ff) || (x2_ff == hi_ff)) && even_ff);

      ecnt_in = ecnt_ff;
      hit_in  = hit_ff;
      inv_in  = inv_ff;
      even_in = even_ff;
      x2_in   = x2_ff;
      step_in = step_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;

      if (start) begin
         // no positions to test when the reduced count is zero (every day wet)
         ecnt_in = (n == 5'd0) ? 5'd0 : day;
         hit_in  = 1'b0;
         inv_in  = inv;
         even_in = ~day[0];
         x2_in   = {6'd0, len, 1'b0};
         step_in = {5'd0, len, 2'b00};
         lo_in   = 12'(12'(dm1) * 12'(n2));
         hi_in   = 12'(12'(dp1) * 12'(n2));
      end else if (ecnt_ff != 5'd0) begin
         // twice the position L*(2e+1)/(2n), tested against day +/- one half
         if (match) begin
            hit_in = 1'b1;
         end
         x2_in   = x2_ff + step_ff;
         ecnt_in = ecnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ecnt_ff <= 5'd0;
         hit_ff  <= 1'b0;
         inv_ff  <= 1'b0;
      end else begin
         ecnt_ff <= ecnt_in;
         hit_ff  <= hit_in;
         inv_ff  <= inv_in;
      end
      even_ff <= even_in;
      x2_ff   <= x2_in;
      step_ff <= step_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
   end

   assign status.busy = ecnt_ff != 5'd0;
   assign status.wet  = hit_ff ^ inv_ff;

endmodule

`default_nettype wire

[hw/rtl/wet_day_precip_spreader_top.sv]
// Top level of the wet-day precipitation spreader.
// Usage:
//  - req_ channel: one word per grid cell and day (amount, month length, day,
//    wet-day count, daily fraction and their missing flags).
//  - rsp_ channel: one word per request: daily amount, wet-day flag, missing flag.
//  - csr_ channel: writes the 2-bit mode register (reset value: spreading).
//    csr_ready is always high; write only while no request is in flight.
//  - One request is worked at a time; req_ready is high while idle.
//  - Path from acceptance to rsp_valid: pass through, a zero count and a
//    missing fraction-mode input go straight to the rounding step; fraction
//    scaling runs the bit-serial multiply, then rounds; a wet day in spreading
//    mode runs the bit-serial multiply, during which the day checker steps
//    through up to 31 event positions, then a bit-serial divide and the
//    rounding step. A dry day skips the divide. Requests do not overlap in the datapath.
//  - The result sits in an output register, so the next request is taken
//    while the last result waits; a finished result holds in the rounding
//    step until the output register frees up.
//  - Reset is synchronous and clears the handshakes and sets mode to spreading.
`default_nettype none

module wet_day_precip_spreader_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_amount,
   input  wire logic        req_amount_missing,
   input  wire logic [4:0]  req_period_length,
   input  wire logic [4:0]  req_day_number,
   input  wire logic [4:0]  req_event_count,
   input  wire logic        req_count_missing,
   input  wire logic [15:0] req_day_fraction,
   input  wire logic        req_fraction_missing,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_daily_amount,
   output logic             rsp_is_event,
   output logic             rsp_out_missing,
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} state_type;

   state_type   state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   logic [5:0]  cyc_ff, cyc_in;
   logic [31:0] amt_ff, amt_in;
   logic [20:0] mult_ff, mult_in;
   logic [52:0] p_ff, p_in;
   logic [4:0]  rem_ff, rem_in;
   logic [4:0]  dvs_ff, dvs_in;
   logic        kind_ff, kind_in;
   logic        zero_ff, zero_in;
   logic        ev_ff, ev_in;
   logic        miss_ff, miss_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_amt_ff, rsp_amt_in;
   logic        rsp_ev_ff, rsp_ev_in;
   logic        rsp_miss_ff, rsp_miss_in;

   logic        accept;
   logic [4:0]  len_c;
   logic [4:0]  cnt_c;
   logic        chk_start;
   wdps_pkg::wdps_wet_status_type chk_status;

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // repaired length and count
   always_comb begin
      logic [4:0] cnt_fix;
      if (int'(req_period_length) > wdps_pkg::MAX_PERIOD) begin
         len_c = 5'(wdps_pkg::MAX_PERIOD);
      end else begin
         len_c = req_period_length;
      end
      cnt_fix = req_count_missing ? 5'd31 : req_event_count;
      cnt_c   = (cnt_fix > len_c) ? len_c : cnt_fix;
   end

   assign chk_start = accept && (mode_ff == wdps_pkg::MODE_WET) && (cnt_c != 5'd0);

   wdps_wet_check u_wet_check (
      .clock  (clock),
      .reset  (reset),
      .start  (chk_start),
      .len    (len_c),
      .cnt    (cnt_c),
      .day    (req_day_number),
      .status (chk_status)
   );

   // sequencer and serial datapath
   always_comb begin
      logic [21:0] sum;
      logic [5:0]  part;
      logic        ge;
      logic [36:0] q;
      logic        inc;
      logic [37:0] rnd;
      logic        out_free;

      state_in     = state_ff;
      mode_in      = mode_ff;
      cyc_in       = cyc_ff;
      amt_in       = amt_ff;
      mult_in      = mult_ff;
      p_in         = p_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      kind_in      = kind_ff;
      zero_in      = zero_ff;
      ev_in        = ev_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_amt_in   = rsp_amt_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_miss_in  = rsp_miss_ff;
      out_free     = !rsp_valid_ff || rsp_ready;

      // multiply step: add the multiplier when the amount bit is set, retire one bit
      sum = {1'b0, p_ff[52:32]} + (amt_ff[0] ? {1'b0, mult_ff} : 22'd0);

      // restoring divide step on the low 37 product bits
      part = {rem_ff, p_ff[36]};
      ge   = part >= {1'b0, dvs_ff};

      // round half to even and saturate
      if (kind_ff) begin
         q   = p_ff[52:16];
         inc = (p_ff[15:0] > 16'h8000) || ((p_ff[15:0] == 16'h8000) && q[0]);
      end else begin
         q   = p_ff[36:0];
         inc = ({rem_ff, 1'b0} > {1'b0, dvs_ff}) ||
               (({rem_ff, 1'b0} == {1'b0, dvs_ff}) && q[0]);
      end
      rnd = {1'b0, q} + {37'd0, inc};

      if (csr_valid) begin
         mode_in = csr_wdata;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cyc_in  = 6'd0;
               p_in    = 53'd0;
               rem_in  = 5'd0;
               dvs_in  = 5'd1;
               kind_in = 1'b0;
               zero_in = 1'b0;
               ev_in   = 1'b0;
               miss_in = 1'b0;
               case (mode_ff)
                  wdps_pkg::MODE_WET: begin
                     amt_in  = req_amount_missing ? 32'd0 : req_amount;
                     mult_in = {16'd0, len_c};
                     dvs_in  = cnt_c;
                     if (cnt_c == 5'd0) begin
                        zero_in  = 1'b1;
                        state_in = ST_FIN;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  wdps_pkg::MODE_FRAC: begin
                     amt_in  = req_amount;
                     mult_in = 21'(21'(req_day_fraction) * 21'(len_c));
                     kind_in = 1'b1;
                     if (req_amount_missing || req_fraction_missing) begin
                        zero_in  = 1'b1;
                        miss_in  = 1'b1;
                        state_in = ST_FIN;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  default: begin
                     // pass through: the amount rides the low product bits
                     p_in     = {21'd0, req_amount};
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_MUL: begin
            p_in   = {sum[21:1], sum[0], p_ff[31:1]};
            amt_in = {1'b0, amt_ff[31:1]};
            cyc_in = cyc_ff + 6'd1;
            if (cyc_ff == 6'd31) begin
               cyc_in = 6'd0;
               if (mode_ff == wdps_pkg::MODE_WET) begin
                  if (chk_status.wet && !chk_status.busy) begin
                     ev_in    = 1'b1;
                     state_in = ST_DIV;
                  end else begin
                     zero_in  = 1'b1;
                     state_in = ST_FIN;
                  end
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_DIV: begin
            rem_in       = ge ? 5'(part - {1'b0, dvs_ff}) : part[4:0];
            p_in[36:0]   = {p_ff[35:0], ge};
            cyc_in       = cyc_ff + 6'd1;
            if (cyc_ff == 6'd36) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ev_in    = ev_ff;
               rsp_miss_in  = miss_ff;
               if (zero_ff) begin
                  rsp_amt_in = 32'd0;
               end else if (rnd[37:32] != 6'd0) begin
                  rsp_amt_in = 32'hFFFF_FFFF;
               end else begin
                  rsp_amt_in = rnd[31:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= wdps_pkg::MODE_WET;
         cyc_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cyc_ff       <= cyc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      amt_ff      <= amt_in;
      mult_ff     <= mult_in;
      p_ff        <= p_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      kind_ff     <= kind_in;
      zero_ff     <= zero_in;
      ev_ff       <= ev_in;
      miss_ff     <= miss_in;
      rsp_amt_ff  <= rsp_amt_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_miss_ff <= rsp_miss_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_daily_amount = rsp_amt_ff;
   assign rsp_is_event     = rsp_ev_ff;
   assign rsp_out_missing  = rsp_miss_ff;

endmodule

`default_nettype wire

[tb/sv/wet_day_precip_spreader_top_test.sv]
// Self-checking testbench for the wet-day precipitation spreader top level.
`timescale 1ns / 1ps

module wet_day_precip_spreader_top_test;

   // spare mode code, decoded like pass through
   localparam logic [1:0] MODE_SPARE = 2'd3;
   // count used when the wet-day count is flagged missing
   localparam logic [4:0] MISSING_COUNT = 5'd31;
   localparam logic [63:0] U32_MAX = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] FRAC_ONE = 64'd65536;

   typedef struct {
      logic [31:0] amount;
      logic        amount_missing;
      logic [4:0]  period_length;
      logic [4:0]  day_number;
      logic [4:0]  event_count;
      logic        count_missing;
      logic [15:0] day_fraction;
      logic        fraction_missing;
   } cell_day_type;

   typedef struct {
      logic [31:0] daily_amount;
      logic        is_event;
      logic        out_missing;
   } day_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_amount = '0;
   logic        req_amount_missing = 1'b0;
   logic [4:0]  req_period_length = '0;
   logic [4:0]  req_day_number = '0;
   logic [4:0]  req_event_count = '0;
   logic        req_count_missing = 1'b0;
   logic [15:0] req_day_fraction = '0;
   logic        req_fraction_missing = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_daily_amount;
   logic        rsp_is_event;
   logic        rsp_out_missing;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_wdata = '0;

   day_result_type day_results_due[$];
   logic [1:0]  mode_now = wdps_pkg::MODE_WET;
   int          mismatches = 0;
   bit          send_idle_on = 1'b1;
   bit          take_idle_on = 1'b1;
   int          hold_ask = 0;
   int          hold_left = 0;

   wet_day_precip_spreader_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_amount           (req_amount),
      .req_amount_missing   (req_amount_missing),
      .req_period_length    (req_period_length),
      .req_day_number       (req_day_number),
      .req_event_count      (req_event_count),
      .req_count_missing    (req_count_missing),
      .req_day_fraction     (req_day_fraction),
      .req_fraction_missing (req_fraction_missing),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_daily_amount     (rsp_daily_amount),
      .rsp_is_event         (rsp_is_event),
      .rsp_out_missing      (rsp_out_missing),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_wdata            (csr_wdata)
   );

   always #6 clock = ~clock;

   // run limit
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

   // ---------------- predictor ----------------

   // divide, round to nearest, ties to even
   function automatic logic [63:0] div_round_even(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = num / den;
      r = num % den;
      if (64'd2 * r > den || (64'd2 * r == den && q[0]))
         q = q + 64'd1;
      return q;
   endfunction

   function automatic logic [31:0] clip_u32(logic [63:0] v);
      return (v > U32_MAX) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   // even spread of cnt wet days over len days; dense months use the dry days
   function automatic bit is_wet_day(int unsigned len, int unsigned cnt, int unsigned day);
      bit          flip;
      int unsigned n;
      int unsigned e;
      flip = 1'b0;
      n = cnt;
      if (n == 0)
         return 1'b0;
      if (n == len)
         return 1'b1;
      if (n > len / 2) begin
         n = len - n;
         flip = 1'b1;
      end
      for (e = 0; e < day; e++) begin
         if (div_round_even(64'(len * (2 * e + 1)), 64'(2 * n)) == 64'(day))
            return !flip;
      end
      return flip;
   endfunction

   function automatic day_result_type daily_amount_for(cell_day_type c, logic [1:0] m);
      day_result_type r;
      logic [63:0] amt;
      logic [63:0] len;
      logic [63:0] cnt;
      r.daily_amount = '0;
      r.is_event = 1'b0;
      r.out_missing = 1'b0;
      amt = 64'(c.amount);
      len = 64'(c.period_length);
      if (len > 64'(wdps_pkg::MAX_PERIOD))
         len = 64'(wdps_pkg::MAX_PERIOD);
      case (m)
         wdps_pkg::MODE_WET: begin
            if (c.amount_missing)
               amt = '0;
            cnt = 64'(c.count_missing ? MISSING_COUNT : c.event_count);
            if (cnt > len)
               cnt = len;
            if (cnt != 0 && is_wet_day(32'(len), 32'(cnt), 32'(c.day_number))) begin
               r.is_event = 1'b1;
               r.daily_amount = clip_u32(div_round_even(amt * len, cnt));
            end
         end
         wdps_pkg::MODE_FRAC: begin
            if (c.amount_missing || c.fraction_missing)
               r.out_missing = 1'b1;
            else
               r.daily_amount = clip_u32(div_round_even(amt * 64'(c.day_fraction) * len,
                                                        FRAC_ONE));
         end
         default: r.daily_amount = c.amount;
      endcase
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic cell_day_type make_cell_day(logic [31:0] amount, logic amiss,
                                                  logic [4:0] len, logic [4:0] day,
                                                  logic [4:0] cnt, logic cmiss,
                                                  logic [15:0] frac, logic fmiss);
      cell_day_type c;
      c.amount = amount;
      c.amount_missing = amiss;
      c.period_length = len;
      c.day_number = day;
      c.event_count = cnt;
      c.count_missing = cmiss;
      c.day_fraction = frac;
      c.fraction_missing = fmiss;
      return c;
   endfunction

   // tidy: a real month, a day inside it, a count up to the length, rare flags
   function automatic cell_day_type random_cell_day(bit tidy);
      cell_day_type c;
      case ($urandom_range(0, 3))
         0:       c.amount = $urandom;
         1:       c.amount = $urandom_range(0, 65535);
         2:       c.amount = 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: c.amount = $urandom_range(0, 800 * 256);
      endcase
      c.day_fraction = 16'($urandom_range(0, 65535));
      if (tidy) begin
         c.period_length = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 31))
                                                       : 5'($urandom_range(28, 31));
         c.day_number = 5'($urandom_range(1, c.period_length));
         c.event_count = 5'($urandom_range(0, c.period_length));
         c.amount_missing = ($urandom_range(0, 19) == 0);
         c.count_missing = ($urandom_range(0, 19) == 0);
         c.fraction_missing = ($urandom_range(0, 19) == 0);
      end else begin
         c.period_length = 5'($urandom_range(0, 31));
         c.day_number = 5'($urandom_range(0, 31));
         c.event_count = 5'($urandom_range(0, 31));
         c.amount_missing = 1'($urandom_range(0, 1));
         c.count_missing = 1'($urandom_range(0, 1));
         c.fraction_missing = 1'($urandom_range(0, 1));
      end
      return c;
   endfunction

   // send one request word; the expectation is queued when it is taken
   task automatic send_cell_day(cell_day_type c);
      if (send_idle_on) begin
         while ($urandom_range(0, 99) < 30) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_amount <= c.amount;
      req_amount_missing <= c.amount_missing;
      req_period_length <= c.period_length;
      req_day_number <= c.day_number;
      req_event_count <= c.event_count;
      req_count_missing <= c.count_missing;
      req_day_fraction <= c.day_fraction;
      req_fraction_missing <= c.fraction_missing;
      do @(posedge clock); while (!req_ready);
      day_results_due.push_back(daily_amount_for(c, mode_now));
   endtask

   // drop valid (called right after a send) and wait for every result
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (day_results_due.size() != 0)
         @(posedge clock);
   endtask

   // only called with nothing in flight
   task automatic write_mode(logic [1:0] m);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_now = m;
   endtask

   task automatic send_random_run(int count, int tidy_pct);
      repeat (count)
         send_cell_day(random_cell_day($urandom_range(0, 99) < tidy_pct));
   endtask

   // ---------------- response side ----------------

   // receiver stalls; a requested hold-off is counted down here
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_ask > 0) begin
         hold_left = hold_ask;
         hold_ask = 0;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (take_idle_on) begin
         rsp_ready <= ($urandom_range(0, 99) >= 30);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s at %0t: expected %h, got %h", what, $time, want, got);
   endtask

   // compare each response word with the oldest expectation
   always @(posedge clock) begin : check_words
      day_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (day_results_due.size() == 0) begin
            note_mismatch("unexpected word", '0, rsp_daily_amount);
         end else begin
            want = day_results_due.pop_front();
            if (rsp_daily_amount !== want.daily_amount)
               note_mismatch("daily_amount", want.daily_amount, rsp_daily_amount);
            if (rsp_is_event !== want.is_event)
               note_mismatch("is_event", 32'(want.is_event), 32'(rsp_is_event));
            if (rsp_out_missing !== want.out_missing)
               note_mismatch("out_missing", 32'(want.out_missing), 32'(rsp_out_missing));
         end
      end
   end

   // ---------------- tests ----------------

   // spreading is the reset mode, no write needed
   task automatic test_reset_mode();
      send_cell_day(make_cell_day(32'd25600, 1'b0, 5'd31, 5'd16, 5'd1, 1'b0, 16'd0, 1'b0));
      send_cell_day(make_cell_day(32'd25600, 1'b0, 5'd30, 5'd7, 5'd30, 1'b0, 16'd0, 1'b0));
      send_random_run(6, 100);
      wait_for_drain();
   endtask

   task automatic test_directed_spreading();
      write_mode(wdps_pkg::MODE_WET);
      // single wet day in a long month, saturated
      send_cell_day(make_cell_day(32'hFFFF_FFFF, 1'b0, 5'd31, 5'd16, 5'd1, 1'b0,
                                  16'hFFFF, 1'b1));
      // dry neighbor of that day
      send_cell_day(make_cell_day(32'hFFFF_FFFF, 1'b0, 5'd31, 5'd15, 5'd1, 1'b0,
                                  16'd0, 1'b0));
      // zero count
      send_cell_day(make_cell_day(32'd1000, 1'b0, 5'd31, 5'd1, 5'd0, 1'b0, 16'd0, 1'b0));
      // zero length
      send_cell_day(make_cell_day(32'd1000, 1'b0, 5'd0, 5'd0, 5'd5, 1'b0, 16'd0, 1'b0));
      // count above length clamps
      send_cell_day(make_cell_day(32'd999, 1'b0, 5'd10, 5'd3, 5'd25, 1'b0, 16'd0, 1'b0));
      // missing count means every day wet
      send_cell_day(make_cell_day(32'd777, 1'b0, 5'd31, 5'd5, 5'd3, 1'b1, 16'd0, 1'b0));
      // dense month, inverted rule
      send_cell_day(make_cell_day(32'd5000, 1'b0, 5'd31, 5'd2, 5'd20, 1'b0, 16'd0, 1'b0));
      // missing amount reads as zero but the day is still wet
      send_cell_day(make_cell_day(32'hFFFF_FFFF, 1'b1, 5'd31, 5'd1, 5'd31, 1'b0,
                                  16'd0, 1'b0));
      // day zero and day past the month end
      send_cell_day(make_cell_day(32'd4096, 1'b0, 5'd31, 5'd0, 5'd10, 1'b0, 16'd0, 1'b0));
      send_cell_day(make_cell_day(32'd4096, 1'b0, 5'd20, 5'd31, 5'd5, 1'b0, 16'd0, 1'b0));
      send_cell_day(make_cell_day(32'd3, 1'b0, 5'd1, 5'd1, 5'd1, 1'b0, 16'd0, 1'b0));
      wait_for_drain();
   endtask

   task automatic test_directed_pass_and_fraction();
      write_mode(wdps_pkg::MODE_PASS);
      send_cell_day(make_cell_day(32'hFFFF_FFFF, 1'b1, 5'd31, 5'd31, 5'd31, 1'b1,
                                  16'hFFFF, 1'b1));
      send_cell_day(make_cell_day(32'd0, 1'b0, 5'd0, 5'd0, 5'd0, 1'b0, 16'd0, 1'b0));
      wait_for_drain();
      write_mode(wdps_pkg::MODE_FRAC);
      // saturation at full fraction
      send_cell_day(make_cell_day(32'hFFFF_FFFF, 1'b0, 5'd31, 5'd1, 5'd0, 1'b0,
                                  16'hFFFF, 1'b0));
      send_cell_day(make_cell_day(32'hFFFF_FFFF, 1'b0, 5'd31, 5'd1, 5'd0, 1'b0,
                                  16'd0, 1'b0));
      // missing amount or fraction
      send_cell_day(make_cell_day(32'd100, 1'b1, 5'd31, 5'd1, 5'd0, 1'b0, 16'd100, 1'b0));
      send_cell_day(make_cell_day(32'd100, 1'b0, 5'd31, 5'd1, 5'd0, 1'b0, 16'd100, 1'b1));
      // rounding ties: 0.5 goes to 0, 1.5 goes to 2
      send_cell_day(make_cell_day(32'd1, 1'b0, 5'd1, 5'd1, 5'd0, 1'b0, 16'd32768, 1'b0));
      send_cell_day(make_cell_day(32'd3, 1'b0, 5'd1, 5'd1, 5'd0, 1'b0, 16'd32768, 1'b0));
      wait_for_drain();
      write_mode(MODE_SPARE);
      send_cell_day(make_cell_day(32'h8000_0001, 1'b1, 5'd31, 5'd16, 5'd1, 1'b0,
                                  16'hFFFF, 1'b1));
      wait_for_drain();
   endtask

   task automatic test_random_spreading();
      write_mode(wdps_pkg::MODE_WET);
      send_random_run(400, 90);
      wait_for_drain();
   endtask

   task automatic test_random_fraction();
      write_mode(wdps_pkg::MODE_FRAC);
      send_random_run(180, 80);
      wait_for_drain();
   endtask

   task automatic test_random_pass();
      write_mode(wdps_pkg::MODE_PASS);
      send_random_run(60, 50);
      wait_for_drain();
      write_mode(MODE_SPARE);
      send_random_run(40, 50);
      wait_for_drain();
   endtask

   // both sides at full rate
   task automatic test_full_rate();
      write_mode(wdps_pkg::MODE_WET);
      send_idle_on = 1'b0;
      take_idle_on = 1'b0;
      send_random_run(100, 90);
      wait_for_drain();
      send_idle_on = 1'b1;
      take_idle_on = 1'b1;
   endtask

   // receiver holds off while words keep coming, so the input stalls
   task automatic test_receiver_hold_off();
      hold_ask = 400;
      send_random_run(10, 90);
      wait_for_drain();
   endtask

   // sender stops until every result is back, then resumes
   task automatic test_sender_pause();
      write_mode(wdps_pkg::MODE_FRAC);
      send_random_run(20, 80);
      wait_for_drain();
      send_random_run(20, 80);
      wait_for_drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_mode();
      test_directed_spreading();
      test_directed_pass_and_fraction();
      test_random_spreading();
      test_random_fraction();
      test_random_pass();
      test_full_rate();
      test_receiver_hold_off();
      test_sender_pause();
      // let any stray word show up
      repeat (100) @(posedge clock);
      if (mismatches == 0 && day_results_due.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
